### rtl/core/bpfu_pkg.sv
// Shared types and codes for the buffer pool with free and used queues.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps

package bpfu_pkg;

  localparam int IDX_W  = 7;
  localparam int WAIT_W = 8;
  localparam int OP_W   = 2;

  // Operation codes as they arrive on the op port.
  localparam logic [OP_W-1:0] OP_GET_FREE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_USED = 2'd1;
  localparam logic [OP_W-1:0] OP_GET_USED = 2'd2;
  localparam logic [OP_W-1:0] OP_RET_FREE = 2'd3;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Classified command, one flag per operation.
  typedef struct packed {
    logic             get_free;
    logic             add_used;
    logic             get_used;
    logic             ret_free;
    logic [IDX_W-1:0] index;
  } cmd_t;

  // One result word as presented at the output ports.
  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  result_index;
    logic              ok;
    logic              reclaimed;
    logic [WAIT_W-1:0] waiting_count;
  } res_t;

endpackage

### rtl/core/bpfu_front.sv
// Front end: accepts commands and classifies the operation code.
// Depends on bpfu_pkg.
`timescale 1ns / 1ps

module bpfu_front (
  input  logic                          start,
  input  logic                          busy,
  input  logic [bpfu_pkg::OP_W-1:0]     op,
  input  logic [bpfu_pkg::IDX_W-1:0]    buffer_index,
  output logic                          push,
  output bpfu_pkg::cmd_t                cmd
);

  assign push = start && !busy;

  always_comb begin
    cmd          = '0;
    cmd.index    = buffer_index;
    unique case (op)
      bpfu_pkg::OP_GET_FREE: cmd.get_free = 1'b1;
      bpfu_pkg::OP_ADD_USED: cmd.add_used = 1'b1;
      bpfu_pkg::OP_GET_USED: cmd.get_used = 1'b1;
      bpfu_pkg::OP_RET_FREE: cmd.ret_free = 1'b1;
      default:               cmd.get_free = 1'b1;
    endcase
  end

endmodule

### rtl/core/bpfu_cmd_queue.sv
// Short queue of classified commands between the front and back ends.
// Depends on bpfu_pkg.
`timescale 1ns / 1ps

module bpfu_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bpfu_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output bpfu_pkg::cmd_t head_cmd
);

  bpfu_pkg::cmd_t                   entries [bpfu_pkg::QDEPTH];
  logic [bpfu_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bpfu_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bpfu_pkg::QCNT_W-1:0]      count;
  logic [bpfu_pkg::QCNT_W-1:0]      count_next;

  assign full     = (count == bpfu_pkg::QCNT_W'(bpfu_pkg::QDEPTH));
  assign valid    = (count != '0);
  assign head_cmd = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && valid)) begin
      count_next = count + bpfu_pkg::QCNT_W'(1);
    end else if (!push && pop && valid) begin
      count_next = count - bpfu_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + bpfu_pkg::QPTR_W'(1);
      end
      if (pop && valid) begin
        rd_ptr <= rd_ptr + bpfu_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/core/bpfu_back.sv
// Back end: holds the free and used queues and carries out one command a cycle.
// Depends on bpfu_pkg.
`timescale 1ns / 1ps

module bpfu_back #(
  parameter int NUM_BUFFERS = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  bpfu_pkg::cmd_t cmd,
  output bpfu_pkg::res_t res
);

  localparam int PW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam logic [PW-1:0] LAST = PW'(NUM_BUFFERS - 1);
  localparam logic [CW-1:0] FULL = CW'(NUM_BUFFERS);

  logic [bpfu_pkg::IDX_W-1:0] free_mem [NUM_BUFFERS];
  logic [bpfu_pkg::IDX_W-1:0] used_mem [NUM_BUFFERS];

  logic [PW-1:0] free_head;
  logic [PW-1:0] free_tail;
  logic [PW-1:0] used_head;
  logic [PW-1:0] used_tail;
  logic [CW-1:0] free_count;
  logic [CW-1:0] used_count;
  logic [CW-1:0] used_count_next;
  logic          free_wrapped;

  logic pop_free;
  logic pop_used;
  logic push_free;
  logic push_used;
  logic ok_c;
  logic recl_c;
  logic fresh_c;

  logic [PW+bpfu_pkg::IDX_W-1:0]  head_ext;
  logic [CW+bpfu_pkg::WAIT_W-1:0] wait_ext;

  // Registered result stage.
  logic                          done;
  logic                          ok;
  logic                          reclaimed;
  logic                          src_free;
  logic                          src_used;
  logic                          fresh;
  logic [bpfu_pkg::IDX_W-1:0]    fresh_idx;
  logic [bpfu_pkg::IDX_W-1:0]    free_rd;
  logic [bpfu_pkg::IDX_W-1:0]    used_rd;
  logic [bpfu_pkg::WAIT_W-1:0]   wait_cnt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    pop_free  = 1'b0;
    pop_used  = 1'b0;
    push_free = 1'b0;
    push_used = 1'b0;
    recl_c    = 1'b0;
    if (cmd_valid) begin
      priority if (cmd.get_free) begin
        if (free_count != '0) begin
          pop_free = 1'b1;
        end else if (used_count != '0) begin
          pop_used = 1'b1;
          recl_c   = 1'b1;
        end
      end else if (cmd.add_used) begin
        push_used = (used_count != FULL);
      end else if (cmd.get_used) begin
        pop_used = (used_count != '0);
      end else if (cmd.ret_free) begin
        push_free = (free_count != FULL);
      end
    end
    ok_c = pop_free || pop_used || push_free || push_used;
  end

  always_comb begin
    used_count_next = used_count;
    if (pop_used) begin
      used_count_next = used_count - CW'(1);
    end else if (push_used) begin
      used_count_next = used_count + CW'(1);
    end
  end

  // The free queue starts out holding each index in its own slot. Pushes fill
  // slots strictly in order from slot zero, so until the tail first wraps, a
  // slot at or beyond the tail has never been written and still holds its
  // initial index, which is the slot number itself.
  assign fresh_c  = !free_wrapped && (free_head >= free_tail);
  assign head_ext = {{bpfu_pkg::IDX_W{1'b0}}, free_head};
  assign wait_ext = {{bpfu_pkg::WAIT_W{1'b0}}, used_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head    <= '0;
      free_tail    <= '0;
      used_head    <= '0;
      used_tail    <= '0;
      free_count   <= FULL;
      used_count   <= '0;
      free_wrapped <= 1'b0;
      done         <= 1'b0;
    end else begin
      done       <= cmd_valid;
      used_count <= used_count_next;
      if (pop_free) begin
        free_head  <= ptr_inc(free_head);
        free_count <= free_count - CW'(1);
      end
      if (push_free) begin
        free_tail  <= ptr_inc(free_tail);
        free_count <= free_count + CW'(1);
        if (free_tail == LAST) begin
          free_wrapped <= 1'b1;
        end
      end
      if (pop_used) begin
        used_head <= ptr_inc(used_head);
      end
      if (push_used) begin
        used_tail <= ptr_inc(used_tail);
      end
    end
  end

  always_ff @(posedge clk) begin
    ok        <= ok_c;
    reclaimed <= recl_c;
    src_free  <= pop_free;
    src_used  <= pop_used;
    fresh     <= fresh_c;
    fresh_idx <= head_ext[bpfu_pkg::IDX_W-1:0];
    wait_cnt  <= wait_ext[bpfu_pkg::WAIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push_free) begin
      free_mem[free_tail] <= cmd.index;
    end
    free_rd <= free_mem[free_head];
  end

  always_ff @(posedge clk) begin
    if (push_used) begin
      used_mem[used_tail] <= cmd.index;
    end
    used_rd <= used_mem[used_head];
  end

  always_comb begin
    res               = '0;
    res.done          = done;
    res.ok            = ok;
    res.reclaimed     = reclaimed;
    res.waiting_count = wait_cnt;
    if (src_free) begin
      res.result_index = fresh ? fresh_idx : free_rd;
    end else if (src_used) begin
      res.result_index = used_rd;
    end
  end

endmodule

### rtl/core/buffer_pool_free_used_queues.sv
// Top level of the buffer pool with a free queue and a used queue.
// Depends on bpfu_pkg, bpfu_front, bpfu_cmd_queue and bpfu_back.
//
//   Channel   Handshake             Words carried
//   --------  --------------------  ------------------------------------------
//   command   start / busy          op, buffer_index
//   result    done (one cycle)      result_index, ok, reclaimed, waiting_count
//
// A command reaches done through the command queue and the back end's registers.
// The back end completes one command per cycle, so a new command may be given
// every cycle; busy rises only if the command queue fills.
// After reset the pool is ready at once: the initial free list is served from
// the head pointer until the free queue's tail first wraps, with no clearing pass.
// Results cannot be held off; each stands on the ports for one cycle.
`timescale 1ns / 1ps

module buffer_pool_free_used_queues #(
  parameter int NUM_BUFFERS = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bpfu_pkg::OP_W-1:0]       op,
  input  logic [bpfu_pkg::IDX_W-1:0]      buffer_index,
  output logic                            done,
  output logic [bpfu_pkg::IDX_W-1:0]      result_index,
  output logic                            ok,
  output logic                            reclaimed,
  output logic [bpfu_pkg::WAIT_W-1:0]     waiting_count
);

  logic           q_push;
  bpfu_pkg::cmd_t q_in;
  logic           q_valid;
  bpfu_pkg::cmd_t q_head;
  bpfu_pkg::res_t res;

  bpfu_front u_front (
    .start        (start),
    .busy         (busy),
    .op           (op),
    .buffer_index (buffer_index),
    .push         (q_push),
    .cmd          (q_in)
  );

  bpfu_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_valid),
    .full     (busy),
    .valid    (q_valid),
    .head_cmd (q_head)
  );

  bpfu_back #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .res       (res)
  );

  assign done          = res.done;
  assign result_index  = res.result_index;
  assign ok            = res.ok;
  assign reclaimed     = res.reclaimed;
  assign waiting_count = res.waiting_count;

endmodule

### rtl/core/bpfu_checker.sv
// Port-level checks for the buffer pool, attached to the top level by bind.
// Depends on buffer_pool_free_used_queues.
`timescale 1ns / 1ps

module bpfu_checker #(
  parameter int NUM_BUFFERS = 128
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [6:0] result_index,
  input logic       ok,
  input logic       reclaimed,
  input logic [7:0] waiting_count
);

  // Every taken command yields a result on done, and no result comes without a taken command.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("command taken without a result two cycles later");

  a_result_has_command: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result with no command behind it");

  a_reclaim_is_success: assert property (@(posedge clk) disable iff (rst)
    (done && reclaimed) |-> ok)
    else $error("reclaim reported on a failed command");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (result_index == 7'd0))
    else $error("failed command returned a non-zero index");

  a_waiting_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> ((NUM_BUFFERS > 255) || (int'(waiting_count) <= NUM_BUFFERS)))
    else $error("waiting count beyond the pool size");

endmodule

bind buffer_pool_free_used_queues bpfu_checker #(
  .NUM_BUFFERS (NUM_BUFFERS)
) u_bpfu_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .result_index  (result_index),
  .ok            (ok),
  .reclaimed     (reclaimed),
  .waiting_count (waiting_count)
);

### tb/tb_buffer_pool_free_used_queues.sv
// Self-checking testbench for buffer_pool_free_used_queues: the free and used queues are
// predicted in the testbench, and each result word is checked against that prediction.
// Depends on bpfu_pkg and the buffer_pool_free_used_queues RTL.
`timescale 1ns / 1ps

module tb_buffer_pool_free_used_queues;
  import bpfu_pkg::*;

  localparam int POOL_SIZE = 128;

  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic              ok;
    logic              reclaimed;
    logic [WAIT_W-1:0] waiting_count;
  } pool_reply_t;

  typedef enum int {
    MIX_EVEN,
    MIX_DRAIN_FREE,
    MIX_FILL_USED,
    MIX_DRAIN_USED,
    MIX_REFILL_FREE
  } traffic_mix_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [OP_W-1:0]   op = OP_GET_FREE;
  logic [IDX_W-1:0]  buffer_index = '0;
  logic              busy;
  logic              done;
  logic [IDX_W-1:0]  result_index;
  logic              ok;
  logic              reclaimed;
  logic [WAIT_W-1:0] waiting_count;

  // Predicted contents of both queues.
  logic [IDX_W-1:0] free_mem [POOL_SIZE];
  logic [IDX_W-1:0] used_mem [POOL_SIZE];
  logic [IDX_W-1:0] free_rd, free_wr, used_rd, used_wr;
  int               free_level, used_level;
  logic [IDX_W-1:0] last_popped = '0;
  pool_reply_t      pending_replies [$];
  int               error_count = 0;

  buffer_pool_free_used_queues #(
    .NUM_BUFFERS(POOL_SIZE)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .buffer_index (buffer_index),
    .done         (done),
    .result_index (result_index),
    .ok           (ok),
    .reclaimed    (reclaimed),
    .waiting_count(waiting_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_buffer_pool_free_used_queues failed");
    $finish;
  end

  function void reset_pool_model();
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_mem[i] = IDX_W'(i);
      used_mem[i] = '0;
    end
    free_rd    = '0;
    free_wr    = '0;
    used_rd    = '0;
    used_wr    = '0;
    free_level = POOL_SIZE;
    used_level = 0;
  endfunction

  // Pointers are IDX_W bits wide, so they wrap at the pool size on their own.
  function automatic pool_reply_t predict_pool_step(input logic [OP_W-1:0] cmd,
                                                    input logic [IDX_W-1:0] idx);
    pool_reply_t r;
    r = '0;
    case (cmd)
      OP_GET_FREE: begin
        if (free_level != 0) begin
          r.result_index = free_mem[free_rd];
          free_rd        = free_rd + 1'b1;
          free_level     = free_level - 1;
          r.ok           = 1'b1;
        end else if (used_level != 0) begin
          // The free queue is dry, so the oldest used buffer is taken back.
          r.result_index = used_mem[used_rd];
          used_rd        = used_rd + 1'b1;
          used_level     = used_level - 1;
          r.ok           = 1'b1;
          r.reclaimed    = 1'b1;
        end
      end
      OP_ADD_USED: begin
        if (used_level < POOL_SIZE) begin
          used_mem[used_wr] = idx;
          used_wr           = used_wr + 1'b1;
          used_level        = used_level + 1;
          r.ok              = 1'b1;
        end
      end
      OP_GET_USED: begin
        if (used_level != 0) begin
          r.result_index = used_mem[used_rd];
          used_rd        = used_rd + 1'b1;
          used_level     = used_level - 1;
          r.ok           = 1'b1;
        end
      end
      OP_RET_FREE: begin
        if (free_level < POOL_SIZE) begin
          free_mem[free_wr] = idx;
          free_wr           = free_wr + 1'b1;
          free_level        = free_level + 1;
          r.ok              = 1'b1;
        end
      end
      default: r = '0;
    endcase
    r.waiting_count = WAIT_W'(used_level);
    return r;
  endfunction

  // Optional idle gap, then one command word held until the block takes it.
  // While idle, op and buffer_index carry junk that the block must ignore.
  task automatic send_word(input logic [OP_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input bit dense, output pool_reply_t reply);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (dense) gap = 0;
    else if (roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start        <= 1'b0;
      op           <= OP_W'($urandom);
      buffer_index <= IDX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    op           <= cmd;
    buffer_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    reply = predict_pool_step(cmd, idx);
    pending_replies.push_back(reply);
    if (reply.ok && (cmd == OP_GET_FREE || cmd == OP_GET_USED)) last_popped = reply.result_index;
  endtask

  always @(posedge clk) begin : check_results
    pool_reply_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word: result_index %0d, ok %0b", result_index, ok);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (result_index !== want.result_index) begin
          $error("result_index: expected %0d, actual %0d", want.result_index, result_index);
          error_count++;
        end
        if (ok !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, ok);
          error_count++;
        end
        if (reclaimed !== want.reclaimed) begin
          $error("reclaimed: expected %0b, actual %0b", want.reclaimed, reclaimed);
          error_count++;
        end
        if (waiting_count !== want.waiting_count) begin
          $error("waiting_count: expected %0d, actual %0d", want.waiting_count, waiting_count);
          error_count++;
        end
      end
    end
  end

  // Empty edge of the used queue, full edge of the free queue, each operation, index extremes.
  task automatic test_directed_edges();
    pool_reply_t r;
    send_word(OP_GET_USED, 7'd127, 1'b0, r);
    send_word(OP_RET_FREE, 7'd127, 1'b0, r);
    send_word(OP_GET_FREE, 7'd127, 1'b0, r);
    send_word(OP_GET_FREE, 7'd0,   1'b0, r);
    send_word(OP_ADD_USED, 7'd0,   1'b0, r);
    send_word(OP_ADD_USED, 7'd127, 1'b0, r);
    send_word(OP_GET_USED, 7'd0,   1'b0, r);
    send_word(OP_RET_FREE, 7'd127, 1'b0, r);
    send_word(OP_RET_FREE, 7'd0,   1'b0, r);
    send_word(OP_RET_FREE, 7'd85,  1'b0, r);
    send_word(OP_GET_USED, 7'd42,  1'b0, r);
    send_word(OP_GET_USED, 7'd42,  1'b0, r);
    send_word(OP_GET_FREE, 7'd42,  1'b0, r);
    send_word(OP_ADD_USED, 7'd42,  1'b0, r);
  endtask

  // Run the pool dry, reclaim from the used queue, then empty and refill.
  task automatic test_pool_exhaustion();
    pool_reply_t r;
    bit          dense;
    dense = $urandom_range(0, 1);
    while (free_level != 0) begin
      send_word(OP_GET_FREE, IDX_W'($urandom), dense, r);
      send_word(OP_ADD_USED, r.result_index, dense, r);
    end
    send_word(OP_ADD_USED, IDX_W'($urandom), 1'b0, r);
    repeat (3) send_word(OP_GET_FREE, IDX_W'($urandom), 1'b0, r);
    dense = $urandom_range(0, 1);
    while (used_level != 0) send_word(OP_GET_USED, IDX_W'($urandom), dense, r);
    // Both queues are empty now, so neither pop can succeed.
    send_word(OP_GET_FREE, IDX_W'($urandom), 1'b0, r);
    send_word(OP_GET_USED, IDX_W'($urandom), 1'b0, r);
    dense = $urandom_range(0, 1);
    while (free_level < POOL_SIZE) send_word(OP_RET_FREE, IDX_W'($urandom), dense, r);
    send_word(OP_RET_FREE, IDX_W'($urandom), 1'b0, r);
  endtask

  // Spans of traffic, each with its own operation mix, so that the queues
  // swing between empty and full. Pushes often reuse the last popped index.
  task automatic test_random_traffic(input int total);
    pool_reply_t      r;
    traffic_mix_e     mix;
    int               sent;
    int               span;
    int               w_gf, w_au, w_gu;
    int               roll;
    bit               dense;
    logic [OP_W-1:0]  cmd;
    logic [IDX_W-1:0] idx;
    sent = 0;
    while (sent < total) begin
      span  = $urandom_range(60, 250);
      if (span > total - sent) span = total - sent;
      dense = ($urandom_range(0, 3) == 0);
      mix   = traffic_mix_e'($urandom_range(0, 4));
      case (mix)
        MIX_EVEN: begin
          w_gf = 25; w_au = 25; w_gu = 25;
        end
        MIX_DRAIN_FREE: begin
          w_gf = 70; w_au = 20; w_gu = 5;
        end
        MIX_FILL_USED: begin
          w_gf = 15; w_au = 70; w_gu = 10;
        end
        MIX_DRAIN_USED: begin
          w_gf = 5; w_au = 5; w_gu = 60;
        end
        default: begin
          w_gf = 5; w_au = 10; w_gu = 15;
        end
      endcase
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (roll < w_gf) cmd = OP_GET_FREE;
        else if (roll < w_gf + w_au) cmd = OP_ADD_USED;
        else if (roll < w_gf + w_au + w_gu) cmd = OP_GET_USED;
        else cmd = OP_RET_FREE;
        idx = $urandom_range(0, 1) ? last_popped : IDX_W'($urandom_range(0, POOL_SIZE - 1));
        send_word(cmd, idx, dense, r);
        sent++;
      end
    end
  endtask

  initial begin
    reset_pool_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_pool_exhaustion();
    test_random_traffic(1320);
    start <= 1'b0;
    for (int w = 0; w < 200 && pending_replies.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d result words never arrived", pending_replies.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_buffer_pool_free_used_queues passed");
    end else begin
      $display("tb_buffer_pool_free_used_queues failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bpfu_pkg.sv
rtl/core/bpfu_front.sv
rtl/core/bpfu_cmd_queue.sv
rtl/core/bpfu_back.sv
rtl/core/buffer_pool_free_used_queues.sv
rtl/core/bpfu_checker.sv
tb/tb_buffer_pool_free_used_queues.sv
